// ===== rtl/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants of the degree sine/cosine pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

   localparam int NUM_TERMS_DEF       = 30;
   localparam int ANGLE_FRAC_BITS_DEF = 8;

   // Reduced angle magnitude: 9 integer bits (< 360) plus up to 16 fraction bits
   localparam int RMAG_W = 25;
   localparam int FRAC_W = 16;

   // round(pi/180 * 2^48)
   localparam logic [63:0] RAD_PER_DEG = 64'd4912665105575;
   localparam logic [63:0] ONE_Q48     = 64'd1 << 48;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   // Divisor (n+1)(n+2) of one series step; fits 12 bits for up to 30 terms
   localparam int DIV_W = 12;

   typedef struct packed {
      logic                kind;   // 0 sine, 1 cosine
      logic                neg;
      logic [RMAG_W-1:0]   rmag;   // |angle mod 360 deg|, same fraction bits as input
   } scd_angle_type;

   typedef struct packed {
      logic        kind;
      logic        tneg;   // sign of the current term
      logic [63:0] tmag;   // magnitude of the current term, Q.48
      logic [63:0] x2;     // x^2, Q.48
      logic [63:0] sum;    // partial sum, two's complement Q.48
   } scd_term_type;

   function automatic logic [63:0] scd_signed_term(input logic neg, input logic [63:0] mag);
      return neg ? (64'd0 - mag) : mag;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/scd_reduce.sv =====
// ----------------------------------------------------------------------------
// scd_reduce
// Two-stage reduction of the input angle modulo 360 degrees (sign kept).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scd_reduce
   import scd_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic               in_kind,
   input  wire logic signed [31:0] in_angle_deg,
   output logic                    out_valid,
   output scd_angle_type           out_angle
);

   localparam logic [31:0] LOW_MASK = (32'd1 << ANGLE_FRAC_BITS) - 32'd1;

   // stage 1: magnitude, split into whole degrees and fraction, fold mod 45
   // (2^12 = 1 mod 45, so 12-bit chunks of degrees/8 add up mod 45)
   logic [31:0] mag;
   logic [31:0] quo;
   logic [13:0] fold_in;
   logic        s1_valid_ff;
   logic        s1_kind_ff;
   logic        s1_neg_ff;
   logic [13:0] s1_fold_ff;
   logic [2:0]  s1_low3_ff;
   logic [FRAC_W-1:0] s1_frac_ff;

   always_comb begin
      mag     = in_angle_deg[31] ? (32'd0 - 32'(in_angle_deg)) : 32'(in_angle_deg);
      quo     = mag >> ANGLE_FRAC_BITS;
      fold_in = {2'b00, quo[14:3]} + {2'b00, quo[26:15]} + {9'd0, quo[31:27]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_kind_ff <= in_kind;
         s1_neg_ff  <= in_angle_deg[31];
         s1_fold_ff <= fold_in;
         s1_low3_ff <= quo[2:0];
         s1_frac_ff <= mag[FRAC_W-1:0] & LOW_MASK[FRAC_W-1:0];
      end
   end

   // stage 2: fold mod 45 by reciprocal estimate and one correction
   logic [24:0]       est_prod;
   logic [8:0]        est;
   logic [14:0]       rem_wide;
   logic [13:0]       rem;
   logic [5:0]        r45;
   logic [RMAG_W-1:0] rmag_in;
   logic              s2_valid_ff;
   scd_angle_type     s2_angle_ff;

   always_comb begin
      est_prod = 25'(s1_fold_ff) * 25'd1456;
      est      = est_prod[24:16];
      rem_wide = {1'b0, s1_fold_ff} - (15'(est) * 15'd45);
      rem      = rem_wide[13:0];
      r45      = (rem >= 14'd45) ? 6'(rem - 14'd45) : rem[5:0];
      rmag_in  = (RMAG_W'({r45, s1_low3_ff}) << ANGLE_FRAC_BITS) | RMAG_W'(s1_frac_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_angle_ff.kind <= s1_kind_ff;
         s2_angle_ff.neg  <= s1_neg_ff;
         s2_angle_ff.rmag <= rmag_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_angle = s2_angle_ff;

endmodule

`default_nettype wire

// ===== rtl/scd_radians.sv =====
// ----------------------------------------------------------------------------
// scd_radians
// Degrees to radians (Q.48) and x^2, four stages, first series term out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scd_radians
   import scd_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire scd_angle_type in_angle,
   output logic               out_valid,
   output scd_term_type       out_term
);

   localparam logic [71:0] HALF = (72'd1 << ANGLE_FRAC_BITS) >> 1;

   // stage A: angle times rad/deg, constant split at bit 32
   logic        a_valid_ff;
   logic        a_kind_ff;
   logic        a_neg_ff;
   logic [63:0] a_lo_ff;
   logic [63:0] a_hi_ff;
   logic [63:0] a_lo_in;
   logic [63:0] a_hi_in;

   assign a_lo_in = 64'(in_angle.rmag) * 64'(RAD_PER_DEG[31:0]);
   assign a_hi_in = 64'(in_angle.rmag) * 64'(RAD_PER_DEG[42:32]);

   // stage B: rounded x
   logic        b_valid_ff;
   logic        b_kind_ff;
   logic        b_neg_ff;
   logic [63:0] b_x_ff;
   logic [71:0] b_prod;
   logic [63:0] b_x_in;

   always_comb begin
      b_prod = 72'(a_lo_ff) + (72'(a_hi_ff) << 32) + HALF;
      b_x_in = 64'(b_prod >> ANGLE_FRAC_BITS);
   end

   // stage C: partial products of x*x
   logic        c_valid_ff;
   logic        c_kind_ff;
   logic        c_neg_ff;
   logic [63:0] c_x_ff;
   logic [63:0] c_hh_ff;
   logic [63:0] c_hl_ff;
   logic [63:0] c_ll_ff;
   logic [63:0] c_hh_in;
   logic [63:0] c_hl_in;
   logic [63:0] c_ll_in;

   assign c_hh_in = 64'(b_x_ff[63:32]) * 64'(b_x_ff[63:32]);
   assign c_hl_in = 64'(b_x_ff[63:32]) * 64'(b_x_ff[31:0]);
   assign c_ll_in = 64'(b_x_ff[31:0])  * 64'(b_x_ff[31:0]);

   // stage D: x2 rounded to Q.48, first term picked
   logic         d_valid_ff;
   scd_term_type d_term_ff;
   logic [127:0] d_sq;
   scd_term_type d_term_in;

   always_comb begin
      d_sq = (128'(c_hh_ff) << 64) + (128'(c_hl_ff) << 33) + 128'(c_ll_ff)
             + (128'd1 << 47);
      d_term_in.kind = c_kind_ff;
      d_term_in.tneg = c_kind_ff ? 1'b0 : c_neg_ff;
      d_term_in.tmag = c_kind_ff ? ONE_Q48 : c_x_ff;
      d_term_in.x2   = d_sq[111:48];
      d_term_in.sum  = 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_kind_ff <= in_angle.kind;
         a_neg_ff  <= in_angle.neg;
         a_lo_ff   <= a_lo_in;
         a_hi_ff   <= a_hi_in;
         b_kind_ff <= a_kind_ff;
         b_neg_ff  <= a_neg_ff;
         b_x_ff    <= b_x_in;
         c_kind_ff <= b_kind_ff;
         c_neg_ff  <= b_neg_ff;
         c_x_ff    <= b_x_ff;
         c_hh_ff   <= c_hh_in;
         c_hl_ff   <= c_hl_in;
         c_ll_ff   <= c_ll_in;
         d_term_ff <= d_term_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_term  = d_term_ff;

endmodule

`default_nettype wire

// ===== rtl/scd_term.sv =====
// ----------------------------------------------------------------------------
// scd_term
// One series step in six stages: t' = -trunc(round(t*x2/2^48) / ((n+1)(n+2))),
// and the current term is added into the running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scd_term
   import scd_pkg::*;
#(
   parameter int TERM_INDEX = 0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire scd_term_type in_term,
   output logic              out_valid,
   output scd_term_type      out_term
);

   // sine: n = 2k+1, cosine: n = 2k
   localparam logic [DIV_W-1:0] DIV_SIN = DIV_W'((2*TERM_INDEX+2) * (2*TERM_INDEX+3));
   localparam logic [DIV_W-1:0] DIV_COS = DIV_W'((2*TERM_INDEX+1) * (2*TERM_INDEX+2));
   localparam logic [63:0] RECIP_SIN = 64'hFFFF_FFFF_FFFF_FFFF / 64'(DIV_SIN);
   localparam logic [63:0] RECIP_COS = 64'hFFFF_FFFF_FFFF_FFFF / 64'(DIV_COS);

   // A: t*x2 partial products, accumulate the current term
   logic         a_valid_ff;
   scd_term_type a_term_ff;
   logic [63:0]  a_hh_ff, a_hl_ff, a_lh_ff, a_ll_ff;
   logic [63:0]  a_sum_in;
   scd_term_type a_term_in;

   assign a_sum_in = in_term.sum + scd_signed_term(in_term.tneg, in_term.tmag);

   always_comb begin
      a_term_in     = in_term;
      a_term_in.sum = a_sum_in;
   end

   // B: rounded product P
   logic         b_valid_ff;
   scd_term_type b_term_ff;
   logic [63:0]  b_p_ff;
   logic [127:0] b_prod;
   logic [63:0]  b_p_in;

   always_comb begin
      b_prod = (128'(a_hh_ff) << 64) + (128'(a_hl_ff) << 32) + (128'(a_lh_ff) << 32)
               + 128'(a_ll_ff) + (128'd1 << 47);
      b_p_in = b_prod[111:48];
   end

   // C: P times reciprocal of the divisor
   logic         c_valid_ff;
   scd_term_type c_term_ff;
   logic [63:0]  c_p_ff;
   logic [63:0]  c_hh_ff, c_hl_ff, c_lh_ff, c_ll_ff;
   logic [63:0]  c_recip;

   assign c_recip = b_term_ff.kind ? RECIP_COS : RECIP_SIN;

   // D: quotient estimate (exact or one short)
   logic         d_valid_ff;
   scd_term_type d_term_ff;
   logic [63:0]  d_p_ff;
   logic [63:0]  d_qe_ff;
   logic [127:0] d_prod;
   logic [63:0]  d_qe_in;

   always_comb begin
      d_prod  = (128'(c_hh_ff) << 64) + (128'(c_hl_ff) << 32) + (128'(c_lh_ff) << 32)
                + 128'(c_ll_ff);
      d_qe_in = d_prod[127:64];
   end

   // E: estimate times divisor
   logic             e_valid_ff;
   scd_term_type     e_term_ff;
   logic [63:0]      e_p_ff;
   logic [63:0]      e_qe_ff;
   logic [63:0]      e_qd_ff;
   logic [DIV_W-1:0] d_div;

   assign d_div = d_term_ff.kind ? DIV_COS : DIV_SIN;

   // F: correction, next term (sign flips)
   logic             f_valid_ff;
   scd_term_type     f_term_ff;
   logic [63:0]      f_rem;
   logic [DIV_W-1:0] f_div;
   scd_term_type     f_term_in;

   always_comb begin
      f_div          = e_term_ff.kind ? DIV_COS : DIV_SIN;
      f_rem          = e_p_ff - e_qd_ff;
      f_term_in      = e_term_ff;
      f_term_in.tneg = ~e_term_ff.tneg;
      f_term_in.tmag = (f_rem >= 64'(f_div)) ? (e_qe_ff + 64'd1) : e_qe_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_term_ff <= a_term_in;
         a_hh_ff <= 64'(in_term.tmag[63:32]) * 64'(in_term.x2[63:32]);
         a_hl_ff <= 64'(in_term.tmag[63:32]) * 64'(in_term.x2[31:0]);
         a_lh_ff <= 64'(in_term.tmag[31:0])  * 64'(in_term.x2[63:32]);
         a_ll_ff <= 64'(in_term.tmag[31:0])  * 64'(in_term.x2[31:0]);

         b_term_ff <= a_term_ff;
         b_p_ff    <= b_p_in;

         c_term_ff <= b_term_ff;
         c_p_ff    <= b_p_ff;
         c_hh_ff   <= 64'(b_p_ff[63:32]) * 64'(c_recip[63:32]);
         c_hl_ff   <= 64'(b_p_ff[63:32]) * 64'(c_recip[31:0]);
         c_lh_ff   <= 64'(b_p_ff[31:0])  * 64'(c_recip[63:32]);
         c_ll_ff   <= 64'(b_p_ff[31:0])  * 64'(c_recip[31:0]);

         d_term_ff <= c_term_ff;
         d_p_ff    <= c_p_ff;
         d_qe_ff   <= d_qe_in;

         e_term_ff <= d_term_ff;
         e_p_ff    <= d_p_ff;
         e_qe_ff   <= d_qe_ff;
         e_qd_ff   <= d_qe_ff * 64'(d_div);

         f_term_ff <= f_term_in;
      end
   end

   assign out_valid = f_valid_ff;
   assign out_term  = f_term_ff;

endmodule

`default_nettype wire

// ===== rtl/scd_finish.sv =====
// ----------------------------------------------------------------------------
// scd_finish
// Adds the last term, rounds the Q.48 sum to Q2.30 and saturates to +-1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scd_finish
   import scd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire scd_term_type in_term,
   output logic              out_valid,
   output logic [31:0]       out_result
);

   logic        s1_valid_ff;
   logic [63:0] s1_sum_ff;
   logic [63:0] s1_sum_in;

   assign s1_sum_in = in_term.sum + scd_signed_term(in_term.tneg, in_term.tmag);

   logic        s2_valid_ff;
   logic [31:0] s2_result_ff;
   logic        neg;
   logic [63:0] mag;
   logic [63:0] rnd;
   logic [31:0] sat;
   logic [31:0] s2_result_in;

   always_comb begin
      neg = s1_sum_ff[63];
      mag = neg ? (64'd0 - s1_sum_ff) : s1_sum_ff;
      rnd = (mag + (64'd1 << 17)) >> 18;   // ties away from zero
      sat = (rnd > ONE_Q30) ? ONE_Q30[31:0] : rnd[31:0];
      s2_result_in = neg ? (32'd0 - sat) : sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sum_ff    <= s1_sum_in;
         s2_result_ff <= s2_result_in;
      end
   end

   assign out_valid  = s2_valid_ff;
   assign out_result = s2_result_ff;

endmodule

`default_nettype wire

// ===== rtl/sine_cosine_degrees_core.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_degrees_core
// Pipelined sine/cosine of a fixed-point angle in degrees, Q2.30 result.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while the skid register is empty, and
// each item yields one result. Two stages reduce the angle modulo 360 degrees
// (sign kept), four convert to radians Q.48 and form x^2, each of the
// NUM_TERMS-1 series steps takes six stages (t*x2 product, rounding,
// reciprocal multiply for the divide by (n+1)(n+2), quotient correction), two
// add the last term and round/saturate, and one is the output register. The
// stages before the output register move on a single enable. A skid register
// behind the output register catches the one item in flight when rsp_stall
// rises, so req_stall is a registered signal that is high only while that
// skid register holds an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_degrees_core
   import scd_pkg::*;
#(
   parameter int NUM_TERMS       = NUM_TERMS_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic signed [31:0] req_angle_deg,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_result
);

   // pipeline advance: frozen only while the skid register is occupied
   logic en;

   // reduction
   logic          red_valid;
   scd_angle_type red_angle;

   scd_reduce #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_reduce (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .in_kind     (req_kind),
      .in_angle_deg(req_angle_deg),
      .out_valid   (red_valid),
      .out_angle   (red_angle)
   );

   // radians and the first term
   logic [NUM_TERMS-1:0] term_valid;
   scd_term_type         term_item [NUM_TERMS];

   scd_radians #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_radians (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (red_valid),
      .in_angle (red_angle),
      .out_valid(term_valid[0]),
      .out_term (term_item[0])
   );

   // series chain: step k turns term k into term k+1 and adds term k
   for (genvar k = 0; k < NUM_TERMS - 1; k++) begin : g_term
      scd_term #(
         .TERM_INDEX(k)
      ) u_term (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (term_valid[k]),
         .in_term  (term_item[k]),
         .out_valid(term_valid[k+1]),
         .out_term (term_item[k+1])
      );
   end

   // last term, rounding, saturation
   logic        fin_valid;
   logic [31:0] fin_result;

   scd_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (term_valid[NUM_TERMS-1]),
      .in_term   (term_item[NUM_TERMS-1]),
      .out_valid (fin_valid),
      .out_result(fin_result)
   );

   // output register plus skid register
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [31:0] skid_data_ff, skid_data_in;
   logic        push;
   logic        pop;

   assign en   = ~skid_valid_ff;
   assign push = en & fin_valid;
   assign pop  = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (pop || !out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = fin_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = fin_result;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall  = skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_data_ff;

endmodule

`default_nettype wire

// ===== rtl/scd_checker.sv =====
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks of the sine/cosine core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_result
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // the input side only stalls while a result is being held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no pending response");

   // results stay within plus or minus one in Q2.30
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_result) <= 32'sd1073741824 &&
                     $signed(rsp_result) >= -32'sd1073741824))
      else $error("result outside plus or minus one");

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("stalled response dropped or changed");

endmodule

bind sine_cosine_degrees_core scd_checker u_scd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_result(rsp_result)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sine_cosine_degrees_core: a bit-exact fixed-point
// predictor computes each result when its item is accepted, and results are
// compared in order under random gaps, random stalls and a long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the expected results and does the fixed-point sine/cosine math.
class trig_scoreboard;
   int          errors;
   logic [31:0] pending_results[$];

   // round(a*b / 2^s), ties away from zero, clamped to the 64-bit range
   function automatic longint scaled_product(longint a, longint b, int s);
      bit           neg;
      logic [63:0]  ua, ub;
      logic [128:0] p;
      logic [128:0] q;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      p   = ua;
      p   = p * ub;
      if (s > 0) p = p + (129'd1 << (s - 1));
      q = p >> s;
      if (q > 129'h7fff_ffff_ffff_ffff) q = 129'h7fff_ffff_ffff_ffff;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic logic [31:0] sincos_deg(bit cosine, logic signed [31:0] angle);
      longint r, x, x2, t, n, sum, res;
      longint period;
      logic [63:0] mag;
      period = longint'(360) << scd_pkg::ANGLE_FRAC_BITS_DEF;
      r   = longint'(angle) % period;   // truncating, keeps sign
      x   = scaled_product(r, longint'(scd_pkg::RAD_PER_DEG), scd_pkg::ANGLE_FRAC_BITS_DEF);
      x2  = scaled_product(x, x, 48);
      t   = cosine ? (longint'(1) << 48) : x;
      n   = cosine ? 0 : 1;
      sum = 0;
      for (int k = 0; k < scd_pkg::NUM_TERMS_DEF; k++) begin
         sum = sum + t;
         t   = -(scaled_product(t, x2, 48) / ((n + 1) * (n + 2)));
         n   = n + 2;
      end
      // to Q2.30, ties away from zero
      if (sum >= 0) begin
         mag = (sum + (64'd1 << 17)) >> 18;
         res = mag;
      end else begin
         mag = (-sum + (64'd1 << 17)) >> 18;
         res = -longint'(mag);
      end
      if (res > (longint'(1) << 30)) res = longint'(1) << 30;
      if (res < -(longint'(1) << 30)) res = -(longint'(1) << 30);
      return res[31:0];
   endfunction

   function void note_angle(bit kind, logic signed [31:0] angle);
      pending_results.push_back(sincos_deg(kind, angle));
   endfunction

   function void check_result(logic [31:0] actual);
      logic [31:0] want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result: expected none actual %0d", $time,
                  $signed(actual));
         errors++;
         return;
      end
      want = pending_results.pop_front();
      if (want !== actual) begin
         $display("%0t: result mismatch: expected %0d actual %0d", $time,
                  $signed(want), $signed(actual));
         errors++;
      end
   endfunction
endclass

module tb;
   import scd_pkg::*;

   localparam bit KIND_SINE   = 1'b0;
   localparam bit KIND_COSINE = 1'b1;
   localparam int DEG         = 256;          // one degree in input units
   localparam int N_RANDOM    = 1130;
   localparam int LATENCY     = 6 * NUM_TERMS_DEF + 3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = 1'b0;
   logic signed [31:0] req_angle_deg = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result;

   trig_scoreboard sb = new();

   bit long_hold_req = 1'b0;   // asks the receiver for one long hold-off
   bit burst_mode    = 1'b0;   // sender runs with no gaps

   sine_cosine_degrees_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_angle_deg (req_angle_deg),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watch both channels: note accepted angles, check accepted results.
   // Values read here are the pre-edge ones, so no race with the NBAs.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_angle(req_kind, req_angle_deg);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_result);
      end
   end

   // Mostly short gaps, a few long ones; none in burst mode.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Offer one item and hold it until accepted. With no gap, valid stays
   // high and only the payload changes, so each signal gets one NBA per step.
   task automatic send_angle(bit kind, logic signed [31:0] angle);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_angle_deg <= angle;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // Random angle: full range, within a few turns, or close to a quadrant point.
   function automatic logic signed [31:0] pick_angle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return $urandom;
      if (r < 75) return $signed($urandom_range(0, 8 * 360 * DEG)) - 4 * 360 * DEG;
      return $signed($urandom_range(0, 16) * 90 * DEG) - 8 * 90 * DEG
             + $signed($urandom_range(0, 8)) - 4;
   endfunction

   // Receiver: free-running stretches, short and long stalls, one long hold.
   initial begin
      int r;
      @(negedge reset);
      forever begin
         r = $urandom_range(0, 99);
         if (long_hold_req) begin
            // long enough for the pipeline to fill and back up the input
            rsp_stall <= 1'b1;
            repeat (3 * LATENCY) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (r < 55) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else if (r < 65) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(100, 300)) @(posedge clock);
         end else if (r < 93) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   // Stimulus
   initial begin
      logic signed [31:0] directed[$];
      directed = '{0, 90 * DEG, 180 * DEG, 270 * DEG, -90 * DEG, 360 * DEG,
                   -360 * DEG, 765 * DEG, 32'sh7fff_ffff, 32'sh8000_0000, -1, 1,
                   360 * DEG - 1, -(360 * DEG - 1), 45 * DEG + 128};
      sb.errors = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, quadrant points, both kinds
      foreach (directed[i]) begin
         send_angle(KIND_SINE, directed[i]);
         send_angle(KIND_COSINE, directed[i]);
      end
      drain_results();

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 200) burst_mode = 1'b1;
         if (i == 230) long_hold_req = 1'b1;   // sender keeps offering
         if (i == 700) burst_mode = 1'b0;
         if (i == 500) drain_results();         // sender pause until empty
         send_angle($urandom_range(0, 1), pick_angle());
      end
      drain_results();
      repeat (LATENCY + 20) @(posedge clock);

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
